>>> design/rskc_pkg.sv
`default_nettype none

package rskc_pkg;

  // Configuration register indexes.
  localparam int unsigned CfgIdxW = 4;
  localparam logic [CfgIdxW-1:0] REG_THRESHOLD    = 4'd0;
  localparam logic [CfgIdxW-1:0] REG_SLOPE        = 4'd1;
  localparam logic [CfgIdxW-1:0] REG_KNEE_WIDTH   = 4'd2;
  localparam logic [CfgIdxW-1:0] REG_KNEE_SCALE   = 4'd3;
  localparam logic [CfgIdxW-1:0] REG_ATTACK       = 4'd4;
  localparam logic [CfgIdxW-1:0] REG_FAST_RELEASE = 4'd5;
  localparam logic [CfgIdxW-1:0] REG_SLOW_RELEASE = 4'd6;
  localparam logic [CfgIdxW-1:0] REG_RMS          = 4'd7;

  // Level reported for zero mean power, -96 dB in Q8.8.
  localparam logic signed [15:0] LEVEL_FLOOR = -16'sd24576;
  // 10*log10(2) dB per octave of power, scaled by 2^24 / 2^16.
  localparam logic [17:0] LOG_DB_SCALE = 18'd197283;
  // log2(10)/20 in Q.16 log2 units per Q8.8 dB, scaled by 2^8.
  localparam logic [13:0] EXP_SCALE = 14'd10885;
  // ceil(2^21 / 3), exact floor division by three for values below 2^21.
  localparam logic [19:0] RECIP3 = 20'd699051;

  // Fractional log2 of a Q1.30 mantissa in [1, 2), sixteen squaring steps.
  function automatic logic [15:0] log2_frac(input logic [63:0] m_in);
    logic [63:0] m;
    logic [15:0] r;
    m = m_in;
    r = '0;
    for (int k = 0; k < 16; k++) begin
      m = (m * m) >> 30;
      r = {r[14:0], 1'b0};
      if (m >= 64'h8000_0000) begin
        r[0] = 1'b1;
        m = m >> 1;
      end
    end
    return r;
  endfunction

  // Entry i of the log2(1 + i/N) table, Q1.16.
  function automatic logic [16:0] log_entry(input int ltb, input int i);
    logic [63:0] m;
    if (i == (1 << ltb)) begin
      return 17'd65536;
    end
    m = 64'((1 << ltb) + i) << (30 - ltb);
    return 17'(log2_frac(m));
  endfunction

  // Entry i of the 2^(-i/N) table, Q1.16, found by bisection on log2_frac.
  function automatic logic [16:0] exp_entry(input int ltb, input int i);
    int target;
    int lo;
    int hi;
    int mid;
    if (i == 0) begin
      return 17'd65536;
    end
    target = 65536 - (i << (16 - ltb));
    lo = 32768;
    hi = 65535;
    for (int k = 0; k < 17; k++) begin
      if (lo < hi) begin
        mid = (lo + hi) >> 1;
        if (int'(log2_frac(64'(mid) << 15)) >= target) begin
          hi = mid;
        end else begin
          lo = mid + 1;
        end
      end
    end
    return 17'(lo);
  endfunction

endpackage

`default_nettype wire

>>> design/rms_soft_knee_compressor_unit.sv
`default_nettype none
// A result is registered once the sequencer has stepped through the states that the branch of
// the static curve (none, straight line or soft knee) and attack or release call for. A new
// input is taken only back in idle, after the previous one has reached the result register;
// the last step holds while the previous result is not taken. This sequencing is set by the
// single shared 34x34 multiplier that the sequencer steps through.
// Reset is asynchronous and active low; it clears the configuration, mean power and envelope.
module rms_soft_knee_compressor_unit #(
  parameter int SAMPLE_BITS    = 24,
  parameter int LOG_TABLE_BITS = 6
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic signed [SAMPLE_BITS-1:0]  sample_in_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic signed [SAMPLE_BITS-1:0]       sample_out_o,
  output logic signed [15:0]                  reduction_db_o,
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [rskc_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [15:0]                    cfg_data_i
);

  localparam int TabN  = 1 << LOG_TABLE_BITS;
  localparam int IdxW  = LOG_TABLE_BITS + 1;
  // Bits kept below the table index in the normalised mantissa and in the exponent fraction.
  localparam int LogSh = 30 - LOG_TABLE_BITS;
  localparam int ExpSh = 16 - LOG_TABLE_BITS;
  // The square of a full-scale sample is brought to Q2.46.
  localparam int SqSh  = 2 * SAMPLE_BITS - 48;
  localparam int SqR   = (SqSh > 0) ? SqSh : 0;
  localparam int SqL   = (SqSh < 0) ? -SqSh : 0;

  // The sequencer walks one item through the mean power update, the level in dB, the knee
  // curve, the envelope and the gain. Each arithmetic state drives the shared multiplier and
  // the product is consumed by the state that follows it.
  typedef enum logic [5:0] {
    ST_IDLE, ST_SQ, ST_SQS, ST_ML, ST_MH, ST_MS, ST_NRM, ST_LI, ST_LG, ST_LM, ST_LV, ST_RD,
    ST_K1, ST_K2, ST_K3, ST_K4, ST_K5, ST_L1, ST_L2, ST_ENV, ST_D1, ST_D2, ST_D3, ST_D4,
    ST_BL, ST_BS, ST_GA, ST_GB, ST_GI, ST_GG, ST_GY, ST_GO
  } state_e;

  state_e state_q;

  // Configuration registers.
  logic signed [15:0] thr_q;
  logic signed [15:0] slope_q;
  logic [12:0]        knee_w_q;
  logic [15:0]        knee_k_q;
  logic [15:0]        att_q;
  logic [15:0]        frel_q;
  logic [15:0]        srel_q;
  logic [15:0]        rmsc_q;

  // Persistent state and working registers.
  logic [47:0]                    mean_q;
  logic signed [15:0]             env_q;
  logic signed [SAMPLE_BITS-1:0]  s_q;
  logic [46:0]                    sq_q;
  logic signed [48:0]             d_q;
  logic signed [67:0]             acc_q;
  logic signed [67:0]             prod_q;
  logic [47:0]                    nx_q;
  logic [5:0]                     z_q;
  logic [2:0]                     step_q;
  logic                           pzero_q;
  logic signed [23:0]             lg_q;
  logic signed [15:0]             lvl_q;
  logic signed [15:0]             gr_q;
  logic signed [17:0]             x_q;
  logic [16:0]                    coeff_q;
  logic [20:0]                    aexp_q;
  logic [16:0]                    gain_q;
  logic                           out_valid_q;
  logic signed [SAMPLE_BITS-1:0]  sample_out_q;
  logic signed [15:0]             red_q;

  // Constant tables, folded at elaboration.
  logic [16:0] log_tab [TabN+1];
  logic [16:0] exp_tab [TabN+1];

  for (genvar gi = 0; gi <= TabN; gi++) begin : g_tab
    assign log_tab[gi] = rskc_pkg::log_entry(LOG_TABLE_BITS, gi);
    assign exp_tab[gi] = rskc_pkg::exp_entry(LOG_TABLE_BITS, gi);
  end

  function automatic logic signed [15:0] clamp_gr(input logic signed [67:0] v);
    if (v > 68'sd0) begin
      return '0;
    end
    if (v < -68'sd32768) begin
      return -16'sd32768;
    end
    return 16'(v);
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [67:0] v);
    if (v > 68'sd32767) begin
      return 16'sd32767;
    end
    if (v < -68'sd32768) begin
      return -16'sd32768;
    end
    return 16'(v);
  endfunction

  // ---------------------------------------------------------------------------
  // Combinational datapath
  // ---------------------------------------------------------------------------
  logic signed [33:0]  mul_a;
  logic signed [33:0]  mul_b;
  logic signed [67:0]  prod_d;
  logic signed [33:0]  s_ext;
  logic [46:0]         sq_w;
  logic signed [48:0]  d_w;
  logic signed [67:0]  tot_w;
  logic [5:0]          sa_w;
  logic                topz_w;
  logic [LOG_TABLE_BITS-1:0] lidx_w;
  logic [IdxW-1:0]     lidx1_w;
  logic [LogSh-1:0]    lrem_w;
  logic signed [17:0]  ldiff_w;
  logic signed [31:0]  lg_w;
  logic signed [17:0]  tl_w;
  logic signed [17:0]  hs_w;
  logic [16:0]         nenv_w;
  logic [16:0]         depth_w;
  logic signed [16:0]  rdiff_w;
  logic signed [19:0]  rc_w;
  logic signed [16:0]  eg_w;
  logic signed [67:0]  bsum_w;
  logic [LOG_TABLE_BITS-1:0] eidx_w;
  logic [IdxW-1:0]     eidx1_w;
  logic [ExpSh-1:0]    erem_w;
  logic signed [17:0]  ediff_w;
  logic signed [17:0]  g_w;
  logic [4:0]          nsh_w;
  logic signed [67:0]  y_w;
  logic signed [67:0]  ymax_w;
  logic signed [67:0]  ymin_w;
  logic signed [SAMPLE_BITS-1:0] ysat_w;

  always_comb begin
    s_ext   = 34'(s_q);
    sq_w    = 47'((prod_q >> SqR) << SqL);
    d_w     = $signed({1'b0, mean_q}) - $signed({2'b00, sq_w});
    tot_w   = acc_q + (prod_q <<< 24);

    // Normalisation searches the leading one in halving strides: 32, 16, 8, 4, 2, 1.
    sa_w    = 6'(6'd32 >> step_q);
    topz_w  = (nx_q >> (7'd48 - 7'(sa_w))) == '0;

    lidx_w  = nx_q[46 -: LOG_TABLE_BITS];
    lidx1_w = {1'b0, lidx_w} + IdxW'(1);
    lrem_w  = nx_q[46-LOG_TABLE_BITS -: LogSh];
    ldiff_w = $signed({1'b0, log_tab[lidx1_w]}) - $signed({1'b0, log_tab[{1'b0, lidx_w}]});
    lg_w    = ((32'sd1 - $signed(32'(z_q))) <<< 16) + $signed(32'(log_tab[{1'b0, lidx_w}]))
              + 32'(prod_q >>> LogSh);

    tl_w    = 18'(lvl_q) - 18'(thr_q);
    hs_w    = $signed(18'(knee_w_q[12:1]));

    nenv_w  = 17'(-(17'(env_q)));
    depth_w = (prod_q[67:21] > 47'd65536) ? 17'd65536 : prod_q[37:21];
    rdiff_w = $signed({1'b0, srel_q}) - $signed({1'b0, frel_q});
    rc_w    = $signed(20'(frel_q)) + 20'(prod_q >>> 16);
    eg_w    = 17'(env_q) - 17'(gr_q);
    // Truncation toward zero of a sum that is never positive: a ceiling shift.
    bsum_w  = prod_q + (68'(gr_q) <<< 16) + 68'sd65535;

    eidx_w  = aexp_q[15 -: LOG_TABLE_BITS];
    eidx1_w = {1'b0, eidx_w} + IdxW'(1);
    erem_w  = aexp_q[ExpSh-1:0];
    ediff_w = $signed({1'b0, exp_tab[eidx1_w]}) - $signed({1'b0, exp_tab[{1'b0, eidx_w}]});
    g_w     = $signed(18'(exp_tab[{1'b0, eidx_w}])) + 18'(prod_q >>> ExpSh);
    nsh_w   = aexp_q[20:16];

    y_w     = prod_q >>> 16;
    ymax_w  = $signed((68'd1 << (SAMPLE_BITS - 1)) - 68'd1);
    ymin_w  = -ymax_w - 68'sd1;
    if (y_w > ymax_w) begin
      ysat_w = SAMPLE_BITS'(ymax_w);
    end else if (y_w < ymin_w) begin
      ysat_w = SAMPLE_BITS'(ymin_w);
    end else begin
      ysat_w = SAMPLE_BITS'(y_w);
    end

    // Operand selection for the shared multiplier.
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      ST_SQ: begin
        mul_a = s_ext;
        mul_b = s_ext;
      end
      ST_ML: begin
        mul_a = 34'(rmsc_q);
        mul_b = 34'(d_q[23:0]);
      end
      ST_MH: begin
        mul_a = 34'(rmsc_q);
        mul_b = 34'($signed(d_q[48:24]));
      end
      ST_LI: begin
        mul_a = 34'(ldiff_w);
        mul_b = 34'(lrem_w);
      end
      ST_LM: begin
        mul_a = 34'(lg_q);
        mul_b = 34'(rskc_pkg::LOG_DB_SCALE);
      end
      ST_K1: begin
        mul_a = 34'(x_q);
        mul_b = 34'(x_q);
      end
      ST_K2: begin
        mul_a = 34'(prod_q[32:0]);
        mul_b = 34'(knee_k_q);
      end
      ST_K3: begin
        mul_a = 34'(slope_q);
        mul_b = 34'(prod_q[20:0]);
      end
      ST_K4: begin
        mul_a = 34'(slope_q);
        mul_b = 34'(acc_q[41:21]);
      end
      ST_L1: begin
        mul_a = 34'(slope_q);
        mul_b = 34'(x_q);
      end
      ST_D1: begin
        mul_a = 34'({nenv_w, 6'b0});
        mul_b = 34'(rskc_pkg::RECIP3);
      end
      ST_D3: begin
        mul_a = 34'(coeff_q);
        mul_b = 34'(rdiff_w);
      end
      ST_BL: begin
        mul_a = 34'(coeff_q);
        mul_b = 34'(eg_w);
      end
      ST_GA: begin
        mul_a = 34'(nenv_w);
        mul_b = 34'(rskc_pkg::EXP_SCALE);
      end
      ST_GI: begin
        mul_a = 34'(ediff_w);
        mul_b = 34'(erem_w);
      end
      // The output product is kept alive while the last step waits for the result register.
      ST_GY, ST_GO: begin
        mul_a = s_ext;
        mul_b = 34'(gain_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod_d = mul_a * mul_b;
  end

  // ---------------------------------------------------------------------------
  // Sequencer, state and registered outputs
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      thr_q        <= '0;
      slope_q      <= '0;
      knee_w_q     <= '0;
      knee_k_q     <= '0;
      att_q        <= '0;
      frel_q       <= '0;
      srel_q       <= '0;
      rmsc_q       <= '0;
      mean_q       <= '0;
      env_q        <= '0;
      s_q          <= '0;
      sq_q         <= '0;
      d_q          <= '0;
      acc_q        <= '0;
      prod_q       <= '0;
      nx_q         <= '0;
      z_q          <= '0;
      step_q       <= '0;
      pzero_q      <= 1'b0;
      lg_q         <= '0;
      lvl_q        <= '0;
      gr_q         <= '0;
      x_q          <= '0;
      coeff_q      <= '0;
      aexp_q       <= '0;
      gain_q       <= '0;
      out_valid_q  <= 1'b0;
      sample_out_q <= '0;
      red_q        <= '0;
    end else begin
      prod_q <= prod_d;

      // Configuration writes; indexes beyond the register list are dropped.
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          rskc_pkg::REG_THRESHOLD:    thr_q    <= $signed(cfg_data_i);
          rskc_pkg::REG_SLOPE:        slope_q  <= $signed(cfg_data_i);
          rskc_pkg::REG_KNEE_WIDTH:   knee_w_q <= cfg_data_i[12:0];
          rskc_pkg::REG_KNEE_SCALE:   knee_k_q <= cfg_data_i;
          rskc_pkg::REG_ATTACK:       att_q    <= cfg_data_i;
          rskc_pkg::REG_FAST_RELEASE: frel_q   <= cfg_data_i;
          rskc_pkg::REG_SLOW_RELEASE: srel_q   <= cfg_data_i;
          rskc_pkg::REG_RMS:          rmsc_q   <= cfg_data_i;
          default: begin
          end
        endcase
      end

      // In the last step the result register is refilled whenever the old result leaves.
      if (out_valid_q && out_ready_i && state_q != ST_GO) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            s_q     <= sample_in_i;
            state_q <= ST_SQ;
          end
        end
        ST_SQ: begin
          state_q <= ST_SQS;
        end
        ST_SQS: begin
          sq_q    <= sq_w;
          d_q     <= d_w;
          state_q <= ST_ML;
        end
        ST_ML: begin
          state_q <= ST_MH;
        end
        ST_MH: begin
          acc_q   <= prod_q + $signed(68'({sq_q, 16'h0000}));
          state_q <= ST_MS;
        end
        ST_MS: begin
          // Mean power is c*mean + (1-c)*sq, rewritten as c*(mean-sq) + sq.
          mean_q  <= tot_w[63:16];
          nx_q    <= tot_w[63:16];
          pzero_q <= (tot_w[63:16] == '0);
          z_q     <= '0;
          step_q  <= '0;
          state_q <= ST_NRM;
        end
        ST_NRM: begin
          if (topz_w) begin
            nx_q <= nx_q << sa_w;
            z_q  <= z_q + sa_w;
          end
          step_q <= step_q + 3'd1;
          if (step_q == 3'd5) begin
            state_q <= ST_LI;
          end
        end
        ST_LI: begin
          state_q <= ST_LG;
        end
        ST_LG: begin
          lg_q    <= 24'(lg_w);
          state_q <= ST_LM;
        end
        ST_LM: begin
          state_q <= ST_LV;
        end
        ST_LV: begin
          lvl_q   <= pzero_q ? rskc_pkg::LEVEL_FLOOR : sat16(prod_q >>> 24);
          state_q <= ST_RD;
        end
        ST_RD: begin
          // Static curve: inside the knee a quadratic, above it a straight line, else no reduction.
          if (slope_q >= 16'sd0) begin
            gr_q    <= '0;
            state_q <= ST_ENV;
          end else if (knee_w_q != '0 && tl_w >= -hs_w && tl_w <= hs_w) begin
            x_q     <= tl_w + hs_w;
            state_q <= ST_K1;
          end else if (tl_w > hs_w) begin
            x_q     <= tl_w;
            state_q <= ST_L1;
          end else begin
            gr_q    <= '0;
            state_q <= ST_ENV;
          end
        end
        ST_K1: begin
          state_q <= ST_K2;
        end
        ST_K2: begin
          state_q <= ST_K3;
        end
        ST_K3: begin
          acc_q   <= prod_q;
          state_q <= ST_K4;
        end
        ST_K4: begin
          acc_q   <= prod_q;
          state_q <= ST_K5;
        end
        ST_K5: begin
          gr_q    <= clamp_gr((acc_q + (prod_q <<< 21)) >>> 35);
          state_q <= ST_ENV;
        end
        ST_L1: begin
          state_q <= ST_L2;
        end
        ST_L2: begin
          gr_q    <= clamp_gr(prod_q >>> 15);
          state_q <= ST_ENV;
        end
        ST_ENV: begin
          if (gr_q < env_q) begin
            coeff_q <= {1'b0, att_q};
            state_q <= ST_BL;
          end else begin
            state_q <= ST_D1;
          end
        end
        ST_D1: begin
          state_q <= ST_D2;
        end
        ST_D2: begin
          coeff_q <= depth_w;
          state_q <= ST_D3;
        end
        ST_D3: begin
          state_q <= ST_D4;
        end
        ST_D4: begin
          coeff_q <= 17'(rc_w);
          state_q <= ST_BL;
        end
        ST_BL: begin
          state_q <= ST_BS;
        end
        ST_BS: begin
          env_q   <= 16'(bsum_w >>> 16);
          state_q <= ST_GA;
        end
        ST_GA: begin
          state_q <= ST_GB;
        end
        ST_GB: begin
          aexp_q  <= prod_q[28:8];
          state_q <= ST_GI;
        end
        ST_GI: begin
          state_q <= ST_GG;
        end
        ST_GG: begin
          gain_q  <= (nsh_w > 5'd16) ? '0 : (17'(g_w) >> nsh_w);
          state_q <= ST_GY;
        end
        ST_GY: begin
          state_q <= ST_GO;
        end
        ST_GO: begin
          // Hold here while the previous result has not yet been taken.
          if (!out_valid_q || out_ready_i) begin
            sample_out_q <= ysat_w;
            red_q        <= env_q;
            out_valid_q  <= 1'b1;
            state_q      <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_ready_o     = (state_q == ST_IDLE);
  assign cfg_ready_o    = 1'b1;
  assign out_valid_o    = out_valid_q;
  assign sample_out_o   = sample_out_q;
  assign reduction_db_o = red_q;

endmodule

`default_nettype wire
